### design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/lcdg_pkg.sv
package lcdg_pkg;

   localparam int DATA_W        = 32;
   localparam int CODE_W        = 8;
   localparam int STEP_W        = 20;
   localparam int COEF_W        = 31;
   localparam int DT_W          = 25;
   localparam int FRAC_BITS_DEF = 24;
   localparam int DAC_SCALE_DEF = 254;
   localparam int CSR_IDX_W     = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_SIGMA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RHO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BETA  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_X0    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y0    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_Z0    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CALIB = 3'd7;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   // clamp a 33-bit signed sum to the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      begin
         if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? S32_MIN : S32_MAX;
         end else begin
            r = v[DATA_W-1:0];
         end
         return r;
      end
   endfunction

   // signed sum of two 32-bit values, saturated
   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      begin
         return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
      end
   endfunction

   // signed difference of two 32-bit values, saturated
   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      begin
         return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
      end
   endfunction

endpackage

### design/lorenz_chaotic_dac_generator_unit.sv
// a restart transaction is handled in the idle state; a calibration tick runs seven products
// through one shared multiplier, each issued and then captured, plus the update
// an output tick runs the Euler step plus two code divisions, x then z, each skipping the
// bit loop when a range is empty or the value is out of range
// throughput: one request at a time; a result still waiting on rsp_tready holds the next
// reset: synchronous, active high; registers take default coefficients and calibration restarts
`include "assert_macros.svh"

module lorenz_chaotic_dac_generator_unit #(
   parameter int FRAC_BITS = lcdg_pkg::FRAC_BITS_DEF,
   parameter int DAC_SCALE = lcdg_pkg::DAC_SCALE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [0] restart, [7:1] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,   // [7:0] x_code, [15:8] z_code
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lcdg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                           csr_data
);

   localparam int W  = lcdg_pkg::DATA_W;
   localparam int CW = lcdg_pkg::CODE_W;
   localparam int SW = lcdg_pkg::STEP_W;

   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
   localparam logic [lcdg_pkg::COEF_W-1:0] SIGMA_RST = lcdg_pkg::COEF_W'(10 * ONE);
   localparam logic [lcdg_pkg::COEF_W-1:0] RHO_RST   = lcdg_pkg::COEF_W'(28 * ONE);
   localparam logic [lcdg_pkg::COEF_W-1:0] BETA_RST  = lcdg_pkg::COEF_W'((8 * ONE + 1) / 3);
   localparam logic [lcdg_pkg::DT_W-1:0]   DT_RST    = lcdg_pkg::DT_W'((ONE + 500) / 1000);
   localparam logic signed [W-1:0]         POS_RST   = W'(ONE);
   localparam logic [SW-1:0]               CALIB_RST = SW'(20000);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_CAPT,
      ST_UPDATE,
      ST_CALIB,
      ST_DIVX,
      ST_WAITX,
      ST_DIVZ,
      ST_WAITZ,
      ST_OUT
   } state_type;

   // products of one Euler step, in issue order
   typedef enum logic [2:0] {
      OP_SIG_YX,
      OP_DX,
      OP_X_RHOZ,
      OP_DY,
      OP_XY,
      OP_BZ,
      OP_DZ
   } op_type;

   // configuration registers
   logic [lcdg_pkg::COEF_W-1:0] sigma_ff, rho_ff, beta_ff;
   logic [lcdg_pkg::DT_W-1:0]   dt_ff;
   logic signed [W-1:0]         x0_ff, y0_ff, z0_ff;
   logic [SW-1:0]               calib_ff;

   state_type           state_ff;
   op_type              op_ff;
   logic signed [W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [W-1:0] x_low_ff, x_high_ff, z_low_ff, z_high_ff;
   logic signed [W-1:0] tmp_ff, tmp2_ff, dx_ff, dy_ff, dz_ff;
   logic [SW-1:0]       step_count_ff;
   logic                emitting_ff;
   logic [CW-1:0]       x_code_ff;
   logic [CW-1:0]       z_code_ff;
   logic                rsp_tvalid_ff;
   logic [15:0]         rsp_tdata_ff;

   logic signed [W-1:0] mul_a, mul_b, mul_res;
   logic signed [W-1:0] dt_ext;
   logic                div_start, div_done;
   logic [CW-1:0]       div_code;
   logic signed [W-1:0] div_v, div_lo, div_hi;
   logic [SW-1:0]       step_in;
   logic [SW-1:0]       calib_eff;
   logic                req_acc;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign dt_ext     = W'(dt_ff);
   assign step_in    = step_count_ff + 1'b1;
   assign calib_eff  = (calib_ff == '0) ? SW'(1) : calib_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RST;
         rho_ff   <= RHO_RST;
         beta_ff  <= BETA_RST;
         dt_ff    <= DT_RST;
         x0_ff    <= POS_RST;
         y0_ff    <= POS_RST;
         z0_ff    <= POS_RST;
         calib_ff <= CALIB_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcdg_pkg::REG_SIGMA: sigma_ff <= csr_data[lcdg_pkg::COEF_W-1:0];
            lcdg_pkg::REG_RHO:   rho_ff   <= csr_data[lcdg_pkg::COEF_W-1:0];
            lcdg_pkg::REG_BETA:  beta_ff  <= csr_data[lcdg_pkg::COEF_W-1:0];
            lcdg_pkg::REG_DT:    dt_ff    <= csr_data[lcdg_pkg::DT_W-1:0];
            lcdg_pkg::REG_X0:    x0_ff    <= csr_data;
            lcdg_pkg::REG_Y0:    y0_ff    <= csr_data;
            lcdg_pkg::REG_Z0:    z0_ff    <= csr_data;
            lcdg_pkg::REG_CALIB: calib_ff <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (op_ff)
         OP_SIG_YX: begin
            mul_a = W'(sigma_ff);
            mul_b = lcdg_pkg::sat_sub(pos_y_ff, pos_x_ff);
         end
         OP_DX: begin
            mul_a = tmp_ff;
            mul_b = dt_ext;
         end
         OP_X_RHOZ: begin
            mul_a = pos_x_ff;
            mul_b = lcdg_pkg::sat_sub(W'(rho_ff), pos_z_ff);
         end
         OP_DY: begin
            mul_a = lcdg_pkg::sat_sub(tmp_ff, pos_y_ff);
            mul_b = dt_ext;
         end
         OP_XY: begin
            mul_a = pos_x_ff;
            mul_b = pos_y_ff;
         end
         OP_BZ: begin
            mul_a = W'(beta_ff);
            mul_b = pos_z_ff;
         end
         OP_DZ: begin
            mul_a = lcdg_pkg::sat_sub(tmp_ff, tmp2_ff);
            mul_b = dt_ext;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   lcdg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res)
   );

   // divider input select, x channel first
   assign div_start = (state_ff == ST_DIVX) || (state_ff == ST_DIVZ);
   assign div_v     = (state_ff == ST_DIVX) ? pos_x_ff  : pos_z_ff;
   assign div_lo    = (state_ff == ST_DIVX) ? x_low_ff  : z_low_ff;
   assign div_hi    = (state_ff == ST_DIVX) ? x_high_ff : z_high_ff;

   lcdg_div #(.DAC_SCALE(DAC_SCALE)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .value (div_v),
      .low   (div_lo),
      .high  (div_hi),
      .done  (div_done),
      .code  (div_code)
   );

   // step sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_SIG_YX;
         pos_x_ff      <= POS_RST;
         pos_y_ff      <= POS_RST;
         pos_z_ff      <= POS_RST;
         x_low_ff      <= lcdg_pkg::S32_MAX;
         z_low_ff      <= lcdg_pkg::S32_MAX;
         x_high_ff     <= lcdg_pkg::S32_MIN;
         z_high_ff     <= lcdg_pkg::S32_MIN;
         step_count_ff <= '0;
         emitting_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // output register: loaded from the out state, cleared once taken
         if (state_ff == ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_tdata[0]) begin
                     pos_x_ff      <= x0_ff;
                     pos_y_ff      <= y0_ff;
                     pos_z_ff      <= z0_ff;
                     x_low_ff      <= lcdg_pkg::S32_MAX;
                     z_low_ff      <= lcdg_pkg::S32_MAX;
                     x_high_ff     <= lcdg_pkg::S32_MIN;
                     z_high_ff     <= lcdg_pkg::S32_MIN;
                     step_count_ff <= '0;
                     emitting_ff   <= 1'b0;
                  end else begin
                     op_ff    <= OP_SIG_YX;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_CAPT;
            end
            ST_CAPT: begin
               case (op_ff)
                  OP_DX:   dx_ff   <= mul_res;
                  OP_DY:   dy_ff   <= mul_res;
                  OP_BZ:   tmp2_ff <= mul_res;
                  OP_DZ:   dz_ff   <= mul_res;
                  default: tmp_ff  <= mul_res;
               endcase
               if (op_ff == OP_DZ) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  op_ff    <= op_type'(op_ff + 1'b1);
                  state_ff <= ST_ISSUE;
               end
            end
            ST_UPDATE: begin
               pos_x_ff <= lcdg_pkg::sat_add(pos_x_ff, dx_ff);
               pos_y_ff <= lcdg_pkg::sat_add(pos_y_ff, dy_ff);
               pos_z_ff <= lcdg_pkg::sat_add(pos_z_ff, dz_ff);
               state_ff <= emitting_ff ? ST_DIVX : ST_CALIB;
            end
            ST_CALIB: begin
               if (pos_x_ff < x_low_ff)  x_low_ff  <= pos_x_ff;
               if (pos_x_ff > x_high_ff) x_high_ff <= pos_x_ff;
               if (pos_z_ff < z_low_ff)  z_low_ff  <= pos_z_ff;
               if (pos_z_ff > z_high_ff) z_high_ff <= pos_z_ff;
               step_count_ff <= step_in;
               if (step_in >= calib_eff) begin
                  pos_x_ff    <= x0_ff;
                  pos_y_ff    <= y0_ff;
                  pos_z_ff    <= z0_ff;
                  emitting_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_DIVX: begin
               state_ff <= ST_WAITX;
            end
            ST_WAITX: begin
               if (div_done) begin
                  x_code_ff <= div_code;
                  state_ff  <= ST_DIVZ;
               end
            end
            ST_DIVZ: begin
               state_ff <= ST_WAITZ;
            end
            ST_WAITZ: begin
               if (div_done) begin
                  z_code_ff <= div_code;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hand the codes to the output register once it is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff <= {z_code_ff, x_code_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a result transaction only comes out of the emitting phase
   `ASSERT_CLK(a_rsp_only_emitting, $rose(rsp_tvalid) |-> emitting_ff, "result while calibrating")
   // a restart transaction clears the calibration state
   `ASSERT_CLK(a_restart_clears, req_acc && req_tdata[0] |=> !emitting_ff && step_count_ff == '0, "restart did not clear")
   // the divider only reports done while the sequencer waits for it
   `ASSERT_CLK(a_div_done_waits, div_done |-> state_ff == ST_WAITX || state_ff == ST_WAITZ, "divider finished outside a wait state")

endmodule

### design/lcdg_mul.sv
module lcdg_mul #(
   parameter int FRAC_BITS = lcdg_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic signed [lcdg_pkg::DATA_W-1:0]   op_a,
   input  logic signed [lcdg_pkg::DATA_W-1:0]   op_b,
   output logic signed [lcdg_pkg::DATA_W-1:0]   result
);

   localparam int PROD_W = 2 * lcdg_pkg::DATA_W;
   localparam int SHR_W  = PROD_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SHR_W-1:0]  shr;

   // registered product
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   // floor shift by the fraction width, then saturate
   always_comb begin
      shr = prod_ff[PROD_W-1:FRAC_BITS];
      if (shr > SHR_W'(lcdg_pkg::S32_MAX)) begin
         result = lcdg_pkg::S32_MAX;
      end else if (shr < SHR_W'(lcdg_pkg::S32_MIN)) begin
         result = lcdg_pkg::S32_MIN;
      end else begin
         result = shr[lcdg_pkg::DATA_W-1:0];
      end
   end

endmodule

### design/lcdg_div.sv
module lcdg_div #(
   parameter int DAC_SCALE = lcdg_pkg::DAC_SCALE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lcdg_pkg::DATA_W-1:0]   value,
   input  logic signed [lcdg_pkg::DATA_W-1:0]   low,
   input  logic signed [lcdg_pkg::DATA_W-1:0]   high,
   output logic                                 done,
   output logic [lcdg_pkg::CODE_W-1:0]          code
);

   localparam int W     = lcdg_pkg::DATA_W;
   localparam int CW    = lcdg_pkg::CODE_W;
   localparam int REM_W = W + CW;
   localparam logic [CW-1:0] SCALE = CW'(DAC_SCALE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN
   } state_type;

   state_type               state_ff;
   logic signed [W:0]       diff_ff;
   logic signed [W:0]       range_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [W-1:0]            dvs_ff;
   logic [$clog2(CW)-1:0]   bit_ff;
   logic [CW-1:0]           code_ff;
   logic                    done_ff;
   logic [REM_W-1:0]        shifted;
   logic [REM_W-1:0]        trial;

   // trial subtraction for the current quotient bit
   always_comb begin
      shifted = REM_W'(dvs_ff) << bit_ff;
      trial   = rem_ff - shifted;
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  diff_ff  <= {value[W-1], value} - {low[W-1], low};
                  range_ff <= {high[W-1], high} - {low[W-1], low};
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (range_ff <= 0 || diff_ff <= 0) begin
                  code_ff  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (diff_ff >= range_ff) begin
                  code_ff  <= SCALE;
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  rem_ff   <= REM_W'(SCALE) * REM_W'(diff_ff[W-1:0]);
                  dvs_ff   <= range_ff[W-1:0];
                  bit_ff   <= '1;
                  code_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (rem_ff >= shifted) begin
                  rem_ff          <= trial;
                  code_ff[bit_ff] <= 1'b1;
               end
               if (bit_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign code = code_ff;

endmodule
